[src/msdfb_pkg.sv]
// Shared constants and types for the multisample depth frame store.
`default_nettype none
package msdfb_pkg;

    localparam int MAX_WIDTH         = 128;
    localparam int MAX_HEIGHT        = 128;
    localparam int SAMPLES_PER_SIDE  = 2;
    localparam int SAMPLES_PER_PIXEL = SAMPLES_PER_SIDE * SAMPLES_PER_SIDE;

    localparam int XW       = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YW       = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int SUB_W    = (SAMPLES_PER_SIDE > 1) ? $clog2(SAMPLES_PER_SIDE) : 1;
    localparam int SAMP_W   = (SAMPLES_PER_PIXEL > 1) ? $clog2(SAMPLES_PER_PIXEL) : 1;
    localparam int PIX_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W   = (PIX_DEPTH > 1) ? $clog2(PIX_DEPTH) : 1;

    localparam int SUM_W    = 8 + $clog2(SAMPLES_PER_PIXEL);
    localparam int RECIP_SH = SUM_W + $clog2(SAMPLES_PER_PIXEL) + 1;
    localparam int RECIP    = ((2 ** RECIP_SH) + SAMPLES_PER_PIXEL - 1) / SAMPLES_PER_PIXEL;
    localparam int PROD_W   = SUM_W + RECIP_SH + 1;

    localparam int IN_W     = 80;
    localparam int OUT_W    = 32;

    localparam logic [23:0] DEPTH_FAR   = 24'hFF_FFFF;
    localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;
    localparam logic [7:0]  FRAME_RESET = 8'd128;

    localparam logic [1:0] OP_SET_PIXEL  = 2'd0;
    localparam logic [1:0] OP_SET_SAMPLE = 2'd1;
    localparam logic [1:0] OP_TESTED     = 2'd2;
    localparam logic [1:0] OP_RESOLVE    = 2'd3;

    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    typedef struct packed {
        logic [23:0] depth;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } sample_t;

    typedef sample_t [SAMPLES_PER_PIXEL-1:0] pixel_t;

    localparam sample_t CLEAR_SAMPLE = '{depth: DEPTH_FAR, red: 8'd0, green: 8'd0, blue: 8'd0};
    localparam pixel_t  CLEAR_PIXEL  = pixel_t'({SAMPLES_PER_PIXEL{CLEAR_SAMPLE}});

endpackage
`default_nettype wire

[src/msdfb_ram.sv]
// Generic simple dual-port RAM with a registered read.
`default_nettype none
module msdfb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                       clk,
    input  wire logic                                       we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                           wdata,
    input  wire logic                                       re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

[src/multisample_depth_framebuffer_unit.sv]
// Top level of the multisample depth frame store: command stream, frame store and resolve.
//
// Each pixel is one memory word holding all of its samples (colour and depth), so every
// in-frame command is a single read-modify-write of one word through the registered read
// port. After reset a clearing pass writes black at far depth to every one of the
// MAX_WIDTH*MAX_HEIGHT pixel words, one word a cycle; s_tready stays low meanwhile while
// register writes are taken as usual. A draw command is accepted with the memory read,
// then modified and written back in ST_MOD; an in-frame resolve then passes through
// ST_DIV, forming the box average through a constant reciprocal multiply into the output
// register, and waits there while an earlier result is still held. Input commands are
// taken while a result waits on the master side.
`default_nettype none
module multisample_depth_framebuffer_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // s_tdata: x_pos[15:0], y_pos[31:16], red[39:32], green[47:40], blue[55:48], depth[79:56]
    input  wire logic [msdfb_pkg::IN_W-1:0]  s_tdata,
    // s_tuser: opcode[1:0]
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // m_tdata: resolved_color[31:0]
    output logic      [msdfb_pkg::OUT_W-1:0] m_tdata
);
    import msdfb_pkg::*;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_MOD   = 2'd2;
    localparam logic [1:0] ST_DIV   = 2'd3;

    logic [1:0]  state_reg, state_next;
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [7:0]  frame_width_reg, frame_height_reg;

    logic [1:0]        item_op_reg;
    logic              item_in_frame_reg;
    logic [ADDR_W-1:0] item_addr_reg;
    logic [SAMP_W-1:0] item_idx_reg;
    logic [7:0]        item_red_reg, item_green_reg, item_blue_reg;
    logic [23:0]       item_depth_reg;

    logic [SUM_W-1:0]  sum_r_reg, sum_g_reg, sum_b_reg;
    logic [SUM_W-1:0]  sum_r_next, sum_g_next, sum_b_next;
    logic              out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]  out_data_reg;

    logic        accept;
    logic        cfg_write;
    logic [15:0] x_pos, y_pos;
    logic [11:0] px_full, py_full;
    logic        x_ok, y_ok;
    logic [SUB_W-1:0]  tx, ty;
    logic [ADDR_W-1:0] in_addr;
    logic [SAMP_W-1:0] in_idx;

    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_waddr;
    pixel_t            ram_wdata, rd_word, wr_word;
    pixel_t            ram_rdata_pix;
    logic              out_load;
    logic [PROD_W-1:0] prod_r, prod_g, prod_b;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    always_comb
    begin
        unique case (paddr[2])
            REG_FRAME_WIDTH:  prdata = {24'd0, frame_width_reg};
            REG_FRAME_HEIGHT: prdata = {24'd0, frame_height_reg};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_RESET;
            frame_height_reg <= FRAME_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_FRAME_WIDTH:  frame_width_reg  <= pwdata[7:0];
                REG_FRAME_HEIGHT: frame_height_reg <= pwdata[7:0];
            endcase
        end
    end

    // Split the Q12.4 positions into pixel and sample indices.
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid & s_tready;
    assign x_pos    = s_tdata[15:0];
    assign y_pos    = s_tdata[31:16];
    assign px_full  = x_pos[15:4];
    assign py_full  = y_pos[15:4];
    assign x_ok = !x_pos[15] && (px_full < {4'd0, frame_width_reg})
                  && (32'(px_full) < MAX_WIDTH);
    assign y_ok = !y_pos[15] && (py_full < {4'd0, frame_height_reg})
                  && (32'(py_full) < MAX_HEIGHT);
    assign tx = SUB_W'((32'(x_pos[3:0]) * SAMPLES_PER_SIDE) >> 4);
    assign ty = SUB_W'((32'(y_pos[3:0]) * SAMPLES_PER_SIDE) >> 4);
    assign in_addr = ADDR_W'(32'(py_full[YW-1:0]) * MAX_WIDTH + 32'(px_full[XW-1:0]));
    assign in_idx  = SAMP_W'(32'(ty) * SAMPLES_PER_SIDE + 32'(tx));

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_op_reg    <= s_tuser;
            item_addr_reg  <= in_addr;
            item_idx_reg   <= in_idx;
            item_red_reg   <= s_tdata[39:32];
            item_green_reg <= s_tdata[47:40];
            item_blue_reg  <= s_tdata[55:48];
            item_depth_reg <= s_tdata[79:56];
        end
        if (state_reg == ST_MOD)
        begin
            sum_r_reg <= sum_r_next;
            sum_g_reg <= sum_g_next;
            sum_b_reg <= sum_b_next;
        end
        if (out_load)
        begin
            out_data_reg <= {prod_r[RECIP_SH +: 8], prod_g[RECIP_SH +: 8],
                             prod_b[RECIP_SH +: 8], ALPHA_OPAQUE};
        end
    end

    // Modify the pixel word read back from the store.
    assign rd_word = ram_rdata_pix;

    always_comb
    begin
        wr_word    = rd_word;
        sum_r_next = '0;
        sum_g_next = '0;
        sum_b_next = '0;
        for (int i = 0; i < SAMPLES_PER_PIXEL; i++)
        begin
            sum_r_next = sum_r_next + SUM_W'(rd_word[i].red);
            sum_g_next = sum_g_next + SUM_W'(rd_word[i].green);
            sum_b_next = sum_b_next + SUM_W'(rd_word[i].blue);
        end
        unique case (item_op_reg)
            OP_SET_PIXEL:
            begin
                for (int i = 0; i < SAMPLES_PER_PIXEL; i++)
                begin
                    wr_word[i].red   = item_red_reg;
                    wr_word[i].green = item_green_reg;
                    wr_word[i].blue  = item_blue_reg;
                end
            end
            OP_SET_SAMPLE:
            begin
                wr_word[item_idx_reg] = '{depth: DEPTH_FAR, red: item_red_reg,
                                          green: item_green_reg, blue: item_blue_reg};
            end
            OP_TESTED:
            begin
                if (item_depth_reg < rd_word[item_idx_reg].depth)
                begin
                    wr_word[item_idx_reg] = '{depth: item_depth_reg, red: item_red_reg,
                                              green: item_green_reg, blue: item_blue_reg};
                end
            end
            OP_RESOLVE:
            begin
                wr_word = CLEAR_PIXEL;
            end
        endcase
    end

    assign ram_re    = accept;
    assign ram_we    = (state_reg == ST_CLEAR) || ((state_reg == ST_MOD) && item_in_frame_reg);
    assign ram_waddr = (state_reg == ST_CLEAR) ? clr_cnt_reg : item_addr_reg;
    assign ram_wdata = (state_reg == ST_CLEAR) ? CLEAR_PIXEL : wr_word;

    msdfb_ram #(
        .WIDTH ($bits(pixel_t)),
        .DEPTH (PIX_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (in_addr),
        .rdata (ram_rdata_pix)
    );

    // Box average through a reciprocal multiply.
    assign prod_r = PROD_W'(sum_r_reg) * PROD_W'(RECIP);
    assign prod_g = PROD_W'(sum_g_reg) * PROD_W'(RECIP);
    assign prod_b = PROD_W'(sum_b_reg) * PROD_W'(RECIP);

    assign out_load = (state_reg == ST_DIV) && (!out_valid_reg || m_tready);

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ADDR_W'(PIX_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_MOD;
                end
            end
            ST_MOD:
            begin
                if ((item_op_reg == OP_RESOLVE) && item_in_frame_reg)
                begin
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_CLEAR;
            clr_cnt_reg       <= '0;
            out_valid_reg     <= 1'b0;
            item_in_frame_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                item_in_frame_reg <= x_ok & y_ok;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef ASSERT_OFF
    a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_CLEAR || state_reg == ST_MOD))
        else $error("store written outside clear or modify phase");

    a_accept_to_mod: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == ST_MOD))
        else $error("accepted beat not followed by modify phase");

    a_no_result_path: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MOD && !(item_op_reg == OP_RESOLVE && item_in_frame_reg))
        |=> (state_reg == ST_IDLE))
        else $error("result path entered without an in-frame resolve");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_DIV))
        else $error("result raised outside the average phase");
`endif

endmodule
`default_nettype wire

[tb/sv/msdfb_checker.sv]
// Prediction and comparison of resolved colours for the multisample depth frame store.
`timescale 1ns / 100ps
module msdfb_checker
    import msdfb_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [31:0]       pwdata,
    input  wire logic              pready,
    input  wire logic              s_tvalid,
    input  wire logic              s_tready,
    // s_tdata: x_pos[15:0], y_pos[31:16], red[39:32], green[47:40], blue[55:48], depth[79:56]
    input  wire logic [IN_W-1:0]   s_tdata,
    // s_tuser: opcode[1:0]
    input  wire logic [1:0]        s_tuser,
    input  wire logic              m_tvalid,
    input  wire logic              m_tready,
    // m_tdata: resolved_color[31:0]
    input  wire logic [OUT_W-1:0]  m_tdata,
    output int                     error_count,
    output int                     pending_count
);

    localparam int STORE_N = MAX_WIDTH * MAX_HEIGHT * SAMPLES_PER_PIXEL;

    logic [23:0] sample_colour [STORE_N];
    logic [23:0] sample_depth  [STORE_N];
    logic [7:0]  width_reg;
    logic [7:0]  height_reg;
    logic [31:0] resolve_expected [$];
    logic [31:0] want_colour;
    int          mismatches;

    initial
    begin
        for (int i = 0; i < STORE_N; i++)
        begin
            sample_colour[i] = 24'd0;
            sample_depth[i]  = DEPTH_FAR;
        end
        width_reg     = FRAME_RESET;
        height_reg    = FRAME_RESET;
        mismatches    = 0;
        error_count   = 0;
        pending_count = 0;
    end

    function automatic logic locate(input logic [15:0] pos, input logic [7:0] limit,
                                    input int maxv, output int pix, output int sub);
        pix = int'(pos[15:4]);
        sub = (int'(pos[3:0]) * SAMPLES_PER_SIDE) >> 4;
        return !pos[15] && (pix < int'(limit)) && (pix < maxv);
    endfunction

    task automatic predict_command(input logic [1:0] op, input logic [IN_W-1:0] beat);
        int          px;
        int          py;
        int          tx;
        int          ty;
        int          base;
        int          idx;
        int          sr;
        int          sg;
        int          sb;
        logic [23:0] rgb;
        logic [23:0] z;
        rgb = {beat[39:32], beat[47:40], beat[55:48]};
        z   = beat[79:56];
        if (!locate(beat[15:0], width_reg, MAX_WIDTH, px, tx))
            return;
        if (!locate(beat[31:16], height_reg, MAX_HEIGHT, py, ty))
            return;
        base = (py * MAX_WIDTH + px) * SAMPLES_PER_PIXEL;
        idx  = base + ty * SAMPLES_PER_SIDE + tx;
        case (op)
            OP_SET_PIXEL:
            begin
                for (int i = 0; i < SAMPLES_PER_PIXEL; i++)
                    sample_colour[base + i] = rgb;
            end
            OP_SET_SAMPLE:
            begin
                sample_colour[idx] = rgb;
                sample_depth[idx]  = DEPTH_FAR;
            end
            OP_TESTED:
            begin
                if (z < sample_depth[idx])
                begin
                    sample_colour[idx] = rgb;
                    sample_depth[idx]  = z;
                end
            end
            OP_RESOLVE:
            begin
                sr = 0;
                sg = 0;
                sb = 0;
                for (int i = 0; i < SAMPLES_PER_PIXEL; i++)
                begin
                    sr += int'(sample_colour[base + i][23:16]);
                    sg += int'(sample_colour[base + i][15:8]);
                    sb += int'(sample_colour[base + i][7:0]);
                    sample_colour[base + i] = 24'd0;
                    sample_depth[base + i]  = DEPTH_FAR;
                end
                sr /= SAMPLES_PER_PIXEL;
                sg /= SAMPLES_PER_PIXEL;
                sb /= SAMPLES_PER_PIXEL;
                resolve_expected.push_back({sr[7:0], sg[7:0], sb[7:0], ALPHA_OPAQUE});
            end
        endcase
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == REG_FRAME_WIDTH)
                    width_reg = pwdata[7:0];
                else
                    height_reg = pwdata[7:0];
            end
            if (s_tvalid && s_tready)
                predict_command(s_tuser, s_tdata);
            if (m_tvalid && m_tready)
            begin
                if (resolve_expected.size() == 0)
                begin
                    $error("resolved_color: expected none, actual %h", m_tdata);
                    mismatches++;
                end
                else
                begin
                    want_colour = resolve_expected.pop_front();
                    if (m_tdata !== want_colour)
                    begin
                        $error("resolved_color: expected %h, actual %h", want_colour, m_tdata);
                        mismatches++;
                    end
                end
            end
            error_count   <= mismatches;
            pending_count <= resolve_expected.size();
        end
    end

endmodule

[tb/sv/multisample_depth_framebuffer_unit_test.sv]
// Stimulus and verdict for the multisample depth frame store.
`timescale 1ns / 100ps
module multisample_depth_framebuffer_unit_test;
    import msdfb_pkg::*;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [2:0]        paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    logic              s_tvalid;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata;
    logic [1:0]        s_tuser;
    logic              m_tvalid;
    logic              m_tready;
    logic [OUT_W-1:0]  m_tdata;
    int                error_count;
    int                pending_count;
    int                send_idle_pct;
    int                recv_idle_pct;

    int frame_widths[12]  = '{128, 1, 7, 0, 255, 128, 16, 3, 129, 0, 0, 128};
    int frame_heights[12] = '{128, 1, 5, 9, 200, 2, 0, 128, 255, 0, 0, 128};

    multisample_depth_framebuffer_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    msdfb_checker frame_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .error_count   (error_count),
        .pending_count (pending_count)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(negedge clk)
        m_tready = ($urandom_range(0, 99) >= recv_idle_pct);

    initial
    begin
        #6_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    task automatic write_reg(input logic idx, input logic [7:0] value);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = {24'($urandom), value};
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic send_cmd(input logic [1:0] op, input logic [15:0] x, input logic [15:0] y,
                            input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                            input logic [23:0] z);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = {z, b, g, r, y, x};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Hold off until every resolve has drained, then let the pipeline settle.
    task automatic drain_results();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending_count != 0)
            @(posedge clk);
        repeat (8)
            @(posedge clk);
    endtask

    function automatic logic [15:0] pick_coord(input int lim);
        int roll;
        int p;
        roll = $urandom_range(0, 99);
        if (lim == 0 || roll < 10)
            return 16'($urandom);
        if (roll < 16)
            return {1'b1, 15'($urandom)};
        if (roll < 22)
            p = $urandom_range(lim, 2047);
        else if (roll < 60)
            p = $urandom_range(0, ((lim < 3) ? lim : 3) - 1);
        else
            p = $urandom_range(0, lim - 1);
        return {p[11:0], 4'($urandom)};
    endfunction

    function automatic logic [7:0] pick_byte();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10)
            return 8'h00;
        if (roll < 20)
            return 8'hFF;
        return 8'($urandom);
    endfunction

    function automatic logic [23:0] pick_depth();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 8)
            return 24'h0;
        if (roll < 16)
            return DEPTH_FAR;
        if (roll < 24)
            return DEPTH_FAR - 24'd1;
        if (roll < 45)
            return 24'($urandom_range(0, 255));
        return 24'($urandom);
    endfunction

    task automatic send_random(input int lim_w, input int lim_h, output logic hit);
        int          roll;
        logic [1:0]  op;
        logic [15:0] x;
        logic [15:0] y;
        roll = $urandom_range(0, 99);
        if (roll < 20)
            op = OP_SET_PIXEL;
        else if (roll < 40)
            op = OP_SET_SAMPLE;
        else if (roll < 75)
            op = OP_TESTED;
        else
            op = OP_RESOLVE;
        x   = pick_coord(lim_w);
        y   = pick_coord(lim_h);
        hit = !x[15] && !y[15] && (int'(x[15:4]) < lim_w) && (int'(y[15:4]) < lim_h);
        send_cmd(op, x, y, pick_byte(), pick_byte(), pick_byte(), pick_depth());
    endtask

    initial
    begin
        int   w;
        int   h;
        int   lim_w;
        int   lim_h;
        int   taken;
        logic hit;
        clk           = 1'b0;
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = 3'd0;
        pwdata        = 32'd0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = OP_SET_PIXEL;
        m_tready      = 1'b0;
        send_idle_pct = 19;
        recv_idle_pct = 72;
        repeat (6)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_reg(REG_FRAME_WIDTH, 8'd128);
        write_reg(REG_FRAME_HEIGHT, 8'd128);

        send_cmd(OP_RESOLVE,    16'h0000, 16'h0000, 8'd0,   8'd0,   8'd0,   24'd0);
        send_cmd(OP_SET_PIXEL,  16'h07F0, 16'h07FF, 8'hFF,  8'hFF,  8'hFF,  24'd0);
        send_cmd(OP_RESOLVE,    16'h07F5, 16'h07F0, 8'd0,   8'd0,   8'd0,   24'd0);
        // one colour per sample, crossing the fraction boundary between columns and rows
        send_cmd(OP_SET_SAMPLE, 16'h0010, 16'h0020, 8'd255, 8'd0,   8'd1,   24'd0);
        send_cmd(OP_SET_SAMPLE, 16'h0018, 16'h0027, 8'd254, 8'd1,   8'd2,   24'd0);
        send_cmd(OP_SET_SAMPLE, 16'h0017, 16'h0028, 8'd0,   8'd255, 8'd3,   24'd0);
        send_cmd(OP_SET_SAMPLE, 16'h001F, 16'h002F, 8'd1,   8'd128, 8'd200, 24'd0);
        send_cmd(OP_RESOLVE,    16'h0010, 16'h0020, 8'd0,   8'd0,   8'd0,   24'd0);
        // far depth never wins, equal depth never wins
        send_cmd(OP_TESTED,     16'h0030, 16'h0030, 8'd10,  8'd20,  8'd30,  DEPTH_FAR);
        send_cmd(OP_TESTED,     16'h0030, 16'h0030, 8'd40,  8'd80,  8'd120, 24'd0);
        send_cmd(OP_TESTED,     16'h0030, 16'h0030, 8'd255, 8'd255, 8'd255, 24'd0);
        send_cmd(OP_SET_SAMPLE, 16'h0030, 16'h0030, 8'd8,   8'd8,   8'd8,   24'd0);
        send_cmd(OP_TESTED,     16'h0030, 16'h0030, 8'd200, 8'd100, 8'd50,  DEPTH_FAR - 24'd1);
        send_cmd(OP_SET_PIXEL,  16'h0030, 16'h0030, 8'd4,   8'd4,   8'd4,   24'd0);
        send_cmd(OP_TESTED,     16'h0030, 16'h0030, 8'd9,   8'd9,   8'd9,   DEPTH_FAR);
        send_cmd(OP_RESOLVE,    16'h0038, 16'h0038, 8'd0,   8'd0,   8'd0,   24'd0);
        // out of frame: negative, one past the edge, most negative, most positive
        send_cmd(OP_SET_PIXEL,  16'hFFFF, 16'h0000, 8'd77,  8'd77,  8'd77,  24'd0);
        send_cmd(OP_RESOLVE,    16'h0800, 16'h0000, 8'd0,   8'd0,   8'd0,   24'd0);
        send_cmd(OP_RESOLVE,    16'h0000, 16'h8000, 8'd0,   8'd0,   8'd0,   24'd0);
        send_cmd(OP_RESOLVE,    16'h7FFF, 16'h7FFF, 8'd0,   8'd0,   8'd0,   24'd0);
        send_cmd(OP_RESOLVE,    16'h0030, 16'h0030, 8'd0,   8'd0,   8'd0,   24'd0);
        send_cmd(OP_TESTED,     16'h07FF, 16'h07FF, 8'd1,   8'd2,   8'd3,   24'd0);
        send_cmd(OP_RESOLVE,    16'h07F0, 16'h07F0, 8'd0,   8'd0,   8'd0,   24'd0);

        for (int blk = 0; blk < 12; blk++)
        begin
            drain_results();
            w = frame_widths[blk];
            h = frame_heights[blk];
            if (blk == 9 || blk == 10)
            begin
                w = $urandom_range(1, MAX_WIDTH);
                h = $urandom_range(1, MAX_HEIGHT);
            end
            write_reg(REG_FRAME_WIDTH, 8'(w));
            write_reg(REG_FRAME_HEIGHT, 8'(h));
            if (blk == 4)
            begin
                send_idle_pct = 72;
                recv_idle_pct = 19;
            end
            if (blk == 8)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            lim_w = (w < MAX_WIDTH) ? w : MAX_WIDTH;
            lim_h = (h < MAX_HEIGHT) ? h : MAX_HEIGHT;
            if (lim_w == 0 || lim_h == 0)
            begin
                repeat (40)
                    send_random(lim_w, lim_h, hit);
            end
            else
            begin
                taken = 0;
                while (taken < 105)
                begin
                    send_random(lim_w, lim_h, hit);
                    if (hit)
                        taken++;
                end
            end
        end

        drain_results();
        if (error_count == 0 && pending_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[multisample_depth_framebuffer_unit.f]
src/msdfb_pkg.sv
src/msdfb_ram.sv
src/multisample_depth_framebuffer_unit.sv
tb/sv/msdfb_checker.sv
tb/sv/multisample_depth_framebuffer_unit_test.sv
